/* design/wis_pkg.sv */
`default_nettype none

package wis_pkg;

    // Field widths fixed by the item and result formats.
    localparam int KIND_BITS     = 2;
    localparam int WEIGHT_W      = 16;
    localparam int FRACTION_W    = 32;
    localparam int INDEX_BITS    = 10;
    localparam int COUNT_BITS    = 11;

    // Configuration port.
    localparam int APB_ADDR_W    = 3;
    localparam int APB_DATA_W    = 32;
    localparam logic [APB_ADDR_W-3:0] REG_REPLICA_SIZE = '0;

    // Item kinds.
    localparam logic [KIND_BITS-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_APPEND = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_DRAW   = 2'd2;

    // Result status codes.
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [WEIGHT_W-1:0]   weight;
        logic [FRACTION_W-1:0] random_fraction;
    } item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  status;
        logic                  last_draw;
    } result_t;

endpackage

`default_nettype wire

/* design/weighted_index_sampler_unit.sv */
`default_nettype none

// Weighted index sampler (roulette-wheel selection with replacement).
// Clear and append commands complete in the cycle they are accepted, so busy
// stays low for them. A draw on an empty or zero-total table returns an error
// result in the cycle after acceptance. A good draw first forms r * total with a
// shift-and-add multiplier, then walks the cumulative table in memory one entry
// per cycle through its registered read port until an entry is picked or the
// last entry is reached. Busy is high while the draw is in progress. Each result
// is presented for exactly one cycle with result_valid high; the receiver
// cannot stall, so it must take every result transfer as it comes.
module weighted_index_sampler_unit #(
    parameter int DEPTH       = 1024,
    parameter int WEIGHT_BITS = 16,
    parameter int RANDOM_BITS = 32
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire wis_pkg::item_t                    item,
    output logic                                   result_valid,
    output wis_pkg::result_t                       result,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wis_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [wis_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [wis_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    import wis_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CUM_W = WEIGHT_BITS + IDX_W;
    localparam int P_W   = RANDOM_BITS + CUM_W;
    localparam int EW    = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      entry_count_reg, entry_count_next;
    logic [COUNT_BITS-1:0] draw_count_reg, draw_count_next;
    logic [COUNT_BITS-1:0] replica_size_reg;
    logic [CUM_W-1:0]      total_reg, total_next;
    logic [IDX_W-1:0]      scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]      data_idx_reg;
    logic                  data_valid_reg, data_valid_next;
    logic [CUM_W-1:0]      rd_data_reg;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg, result_next;

    logic [CUM_W-1:0]      table_mem [DEPTH];

    logic                  accept;
    logic                  table_we;
    logic [IDX_W-1:0]      table_waddr;
    logic [CUM_W-1:0]      table_wdata;
    logic [31:0]           weight_ext;
    logic [CUM_W-1:0]      prev_cum;
    logic [CNT_W-1:0]      count_m1;
    logic [IDX_W-1:0]      last_idx;
    logic                  mul_start;
    logic                  mul_done;
    logic [P_W-1:0]        product;
    logic                  hit;
    logic                  finish;
    logic [31:0]           pick_ext;
    logic [EW-1:0]         rep_ext;
    logic [EW-1:0]         ent_ext;
    logic [EW-1:0]         eff_size;
    logic [COUNT_BITS-1:0] draw_inc;
    logic                  replica_end;
    logic                  cfg_write;

    assign accept     = start && (state_reg == ST_IDLE);
    assign weight_ext = 32'(item.weight);
    assign prev_cum   = (entry_count_reg != '0) ? total_reg : '0;
    assign count_m1   = entry_count_reg - CNT_W'(1);
    assign last_idx   = count_m1[IDX_W-1:0];

    // Append writes the next cumulative entry while there is room.
    assign table_we    = accept && (item.kind == KIND_APPEND)
                         && (entry_count_reg < CNT_W'(DEPTH));
    assign table_waddr = entry_count_reg[IDX_W-1:0];
    assign table_wdata = prev_cum + CUM_W'(weight_ext[WEIGHT_BITS-1:0]);

    // A draw needs the multiplier only when the table holds weight.
    assign mul_start = accept && (item.kind == KIND_DRAW)
                       && (entry_count_reg != '0) && (total_reg != '0);

    wis_mult #(
        .A_W (RANDOM_BITS),
        .B_W (CUM_W)
    ) u_mult (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (item.random_fraction[RANDOM_BITS-1:0]),
        .b       (total_reg),
        .done    (mul_done),
        .product (product)
    );

    // Scaled compare: cumulative * 2^RANDOM_BITS against r * total.
    assign hit    = {rd_data_reg, {RANDOM_BITS{1'b0}}} > product;
    assign finish = (state_reg == ST_SCAN) && data_valid_reg
                    && (hit || (data_idx_reg == last_idx));

    // Replica bookkeeping for a good draw.
    assign rep_ext     = EW'(replica_size_reg);
    assign ent_ext     = EW'(entry_count_reg);
    assign eff_size    = ((rep_ext == '0) || (rep_ext > ent_ext)) ? ent_ext : rep_ext;
    assign draw_inc    = draw_count_reg + COUNT_BITS'(1);
    assign replica_end = EW'(draw_inc) >= eff_size;
    assign pick_ext    = 32'(data_idx_reg);

    // Sequencer and command handling.
    always_comb
    begin
        state_next        = state_reg;
        entry_count_next  = entry_count_reg;
        draw_count_next   = draw_count_reg;
        total_next        = total_reg;
        scan_addr_next    = scan_addr_reg;
        data_valid_next   = 1'b0;
        result_valid_next = 1'b0;
        result_next       = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.kind)
                        KIND_CLEAR:
                        begin
                            entry_count_next = '0;
                            draw_count_next  = '0;
                        end
                        KIND_APPEND:
                        begin
                            if (table_we)
                            begin
                                entry_count_next = entry_count_reg + CNT_W'(1);
                                total_next       = table_wdata;
                            end
                        end
                        KIND_DRAW:
                        begin
                            if (mul_start)
                            begin
                                state_next = ST_MUL;
                            end
                            else
                            begin
                                result_valid_next     = 1'b1;
                                result_next.index     = '0;
                                result_next.status    = STATUS_EMPTY;
                                result_next.last_draw = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    state_next     = ST_SCAN;
                    scan_addr_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (finish)
                begin
                    state_next            = ST_IDLE;
                    result_valid_next     = 1'b1;
                    result_next.index     = pick_ext[INDEX_BITS-1:0];
                    result_next.status    = STATUS_OK;
                    result_next.last_draw = replica_end;
                    draw_count_next       = replica_end ? '0 : draw_inc;
                end
                else
                begin
                    data_valid_next = 1'b1;
                    if (scan_addr_reg != last_idx)
                    begin
                        scan_addr_next = scan_addr_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            entry_count_reg  <= '0;
            draw_count_reg   <= '0;
            data_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            entry_count_reg  <= entry_count_next;
            draw_count_reg   <= draw_count_next;
            data_valid_reg   <= data_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        total_reg     <= total_next;
        scan_addr_reg <= scan_addr_next;
        data_idx_reg  <= scan_addr_reg;
        result_reg    <= result_next;
    end

    // Cumulative table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (table_we)
        begin
            table_mem[table_waddr] <= table_wdata;
        end
        rd_data_reg <= table_mem[scan_addr_reg];
    end

    // Configuration register.
    assign cfg_write = psel && penable && pwrite
                       && (paddr[APB_ADDR_W-1:2] == REG_REPLICA_SIZE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replica_size_reg <= '0;
        end
        else if (cfg_write)
        begin
            replica_size_reg <= pwdata[COUNT_BITS-1:0];
        end
    end

    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_REPLICA_SIZE)
                    ? APB_DATA_W'(replica_size_reg) : '0;
    assign pready = 1'b1;

    assign busy         = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

/* design/wis_mult.sv */
`default_nettype none

// Shift-and-add multiplier: one bit of the multiplier operand per cycle,
// most significant bit first. The product holds after done until the next start.
module wis_mult #(
    parameter int A_W = 32,
    parameter int B_W = 26
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [A_W-1:0]     a,
    input  wire logic [B_W-1:0]     b,
    output logic                    done,
    output logic [A_W+B_W-1:0]      product
);

    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(A_W + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic [A_W-1:0]   a_reg, a_next;
    logic [B_W-1:0]   b_reg, b_next;
    logic [P_W-1:0]   prod_reg, prod_next;
    logic             done_reg, done_next;
    logic [P_W-1:0]   addend;

    // Add the multiplicand to the shifted partial product when the current operand bit is set.
    assign addend = a_reg[A_W-1] ? P_W'(b_reg) : '0;

    always_comb
    begin
        count_next = count_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        prod_next  = prod_reg;
        done_next  = 1'b0;
        if (start)
        begin
            count_next = CNT_W'(A_W);
            a_next     = a;
            b_next     = b;
            prod_next  = '0;
        end
        else if (count_reg != '0)
        begin
            prod_next  = (prod_reg << 1) + addend;
            a_next     = a_reg << 1;
            count_next = count_reg - CNT_W'(1);
            done_next  = (count_reg == CNT_W'(1));
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire
